// ===== hdl/event_flag_table_assert.svh =====
// ----------------------------------------------------------------------------
// Event flag table assertion macros
// Concurrent assertion helpers shared by the event flag table modules. The
// macros expect clk and arst_n in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_TABLE_ASSERT_SVH
`define EVENT_FLAG_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define EFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define EFT_ASSERT_NOW(label, ante, cons, msg)
`define EFT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/eft_pkg.sv =====
// ----------------------------------------------------------------------------
// Event flag table package
// Sizes, request and status codes, and the request and response payloads.
// ----------------------------------------------------------------------------
package eft_pkg;

	localparam int unsigned NUM_FLAGS    = 16;
	localparam int unsigned PATTERN_BITS = 64;
	localparam int unsigned SLOT_W       = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_SET    = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_POLL   = 3'd4;
	localparam logic [2:0] REQ_CANCEL = 3'd5;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOFLAG = 3'd1,
		ST_BUSY   = 3'd2,
		ST_UNSAT  = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  flag_id;
		logic [63:0] bits;
		logic        or_mode;
		logic        clear_all;
		logic        clear_tested;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] result_bits;
		logic [3:0]  new_id;
	} rsp_t;

endpackage

// ===== hdl/event_flag_table.sv =====
// ----------------------------------------------------------------------------
// Event flag table
// Sixteen event flag slots with create, delete, set, clear, poll and cancel
// requests, one response per request.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------
//   req     | in        | req_valid, req_ready | req_t (type, id, bits, mode)
//   rsp     | out       | rsp_valid, rsp_ready | rsp_t (status, bits, new_id)
//
// A request is registered in the input stage, then decoded against the table and
// committed, with its response registered, once the response stage can move.
// One request per cycle is sustained while the response side does not stall; the
// single read-modify-write of one pattern entry in the commit cycle sets that figure.
// Reset clears all slot valid bits and the valid flags of both pipeline stages.
// A stalled response holds the commit stage; the input stage takes one more.
// ----------------------------------------------------------------------------
`include "event_flag_table_assert.svh"

module event_flag_table
	import eft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	eft_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	`EFT_ASSERT_NEXT(a_commit_gives_response, advance, rsp_valid,
		"committed transaction produced no response")
	`EFT_ASSERT_NOW(a_stall_only_when_full, !req_ready,
		valid_s1 && rsp_valid_q && !rsp_ready, "input stalled while pipeline could move")
	`EFT_ASSERT_NEXT(a_accept_fills_stage, req_valid && req_ready, valid_s1,
		"accepted transaction missing from input stage")

endmodule

// ===== hdl/eft_table.sv =====
// ----------------------------------------------------------------------------
// Event flag table storage and request logic
// Holds the slot patterns and valid bits, works out the response to one
// request and commits its update when enabled.
// ----------------------------------------------------------------------------
`include "event_flag_table_assert.svh"

module eft_table
	import eft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  req_t req,
	output rsp_t rsp
);

	logic [PATTERN_BITS-1:0] pattern_q [NUM_FLAGS];
	logic [NUM_FLAGS-1:0]    valid_q;

	logic                    free_found;
	logic [SLOT_W-1:0]       free_idx;
	logic [SLOT_W-1:0]       idx;
	logic                    hit;
	logic [PATTERN_BITS-1:0] b;
	logic [PATTERN_BITS-1:0] cur;
	logic [PATTERN_BITS-1:0] m;
	logic                    sat;

	logic                    wr_en;
	logic [SLOT_W-1:0]       wr_idx;
	logic [PATTERN_BITS-1:0] wr_data;
	logic                    vset;
	logic                    vclr;

	// Lowest free slot: scan from the top so the lowest index wins.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign idx = SLOT_W'(req.flag_id);
	assign hit = (32'(req.flag_id) < NUM_FLAGS) && valid_q[idx];
	assign b   = req.bits[PATTERN_BITS-1:0];
	assign cur = pattern_q[idx];
	assign m   = cur & b;
	assign sat = req.or_mode ? (m != '0) : ((m == b) && (m != '0));

	always_comb begin
		rsp.status      = ST_OK;
		rsp.result_bits = '0;
		rsp.new_id      = '0;
		wr_en           = 1'b0;
		wr_idx          = idx;
		wr_data         = cur;
		vset            = 1'b0;
		vclr            = 1'b0;
		if (req.req_type == REQ_CREATE) begin
			if (free_found) begin
				rsp.new_id = 4'(free_idx);
				wr_en      = 1'b1;
				wr_idx     = free_idx;
				wr_data    = b;
				vset       = 1'b1;
			end else begin
				rsp.status = ST_FULL;
			end
		end else if (!hit || !(req.req_type inside {REQ_DELETE, REQ_SET, REQ_CLEAR,
				REQ_POLL, REQ_CANCEL})) begin
			rsp.status = ST_NOFLAG;
		end else begin
			case (req.req_type)
				REQ_DELETE: begin
					vclr = 1'b1;
				end
				REQ_SET: begin
					wr_en   = 1'b1;
					wr_data = cur | b;
				end
				REQ_CLEAR: begin
					wr_en   = 1'b1;
					wr_data = cur & ~b;
				end
				REQ_POLL: begin
					if (!sat) begin
						rsp.status = (!req.or_mode && (m != '0)) ? ST_BUSY : ST_UNSAT;
					end else begin
						rsp.result_bits = 64'(m);
						if (req.clear_all) begin
							wr_en   = 1'b1;
							wr_data = '0;
						end else if (req.clear_tested) begin
							wr_en   = 1'b1;
							wr_data = cur & ~b;
						end
					end
				end
				REQ_CANCEL: begin
					rsp.result_bits = 64'(cur);
				end
				default: begin
					rsp.status = ST_NOFLAG;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			pattern_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			if (vset) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (vclr) begin
				valid_q[idx] <= 1'b0;
			end
		end
	end

	`EFT_ASSERT_NOW(a_full_only_when_all_used, en && (rsp.status == ST_FULL), &valid_q,
		"create reported table full while a slot was free")
	`EFT_ASSERT_NEXT(a_delete_frees_slot,
		en && (req.req_type == REQ_DELETE) && (rsp.status == ST_OK), !valid_q[$past(idx)],
		"deleted slot still valid")
	`EFT_ASSERT_NOW(a_result_only_on_ok, en && (rsp.result_bits != '0), rsp.status == ST_OK,
		"nonzero result bits on a failed transaction")

endmodule

// ===== test/event_flag_table_tb.sv =====
// ----------------------------------------------------------------------------
// Event flag table testbench
// Drives create, delete, set, clear, poll and cancel requests into the table
// and checks every response against a predictor that keeps its own copy of the
// slot patterns and valid bits. A directed pass covers the corner cases, then
// random traffic runs with gaps and stalls on both channels, a long response
// hold-off that backs up the request side, and pauses that drain the responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_flag_table_tb;
	import eft_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Predictor state.
	logic [63:0]          tbl_pattern [NUM_FLAGS];
	logic [NUM_FLAGS-1:0] tbl_valid;

	rsp_t pending_rsps[$];
	int   mismatch_count;
	int   cycle_count;
	bit   idle_en;
	int   rsp_hold_cycles;

	event_flag_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Computes the response to one request and applies its effect on the table.
	function automatic rsp_t predict_flag_rsp(input req_t r);
		rsp_t        o;
		logic [63:0] hit_bits;
		bit          sat;
		bit          found;
		o.status      = ST_OK;
		o.result_bits = '0;
		o.new_id      = '0;
		if (r.req_type == REQ_CREATE) begin
			o.status = ST_FULL;
			found    = 1'b0;
			for (int i = 0; i < NUM_FLAGS; i++) begin
				if (!found && !tbl_valid[i]) begin
					found          = 1'b1;
					tbl_valid[i]   = 1'b1;
					tbl_pattern[i] = r.bits;
					o.new_id       = 4'(i);
					o.status       = ST_OK;
				end
			end
		end else if (r.req_type > REQ_CANCEL || !tbl_valid[r.flag_id]) begin
			o.status = ST_NOFLAG;
		end else begin
			case (r.req_type)
				REQ_DELETE: begin
					tbl_valid[r.flag_id] = 1'b0;
				end
				REQ_SET: begin
					tbl_pattern[r.flag_id] = tbl_pattern[r.flag_id] | r.bits;
				end
				REQ_CLEAR: begin
					tbl_pattern[r.flag_id] = tbl_pattern[r.flag_id] & ~r.bits;
				end
				REQ_POLL: begin
					hit_bits = tbl_pattern[r.flag_id] & r.bits;
					sat = r.or_mode ? (hit_bits != '0) : (hit_bits == r.bits && hit_bits != '0);
					if (!sat) begin
						o.status = (!r.or_mode && hit_bits != '0) ? ST_BUSY : ST_UNSAT;
					end else begin
						o.result_bits = hit_bits;
						if (r.clear_all)
							tbl_pattern[r.flag_id] = '0;
						else if (r.clear_tested)
							tbl_pattern[r.flag_id] = tbl_pattern[r.flag_id] & ~r.bits;
					end
				end
				default: begin
					o.result_bits = tbl_pattern[r.flag_id];
				end
			endcase
		end
		return o;
	endfunction

	// Mostly zero, sometimes a few cycles, now and then a long gap.
	function automatic int pick_idle_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		else if (sel < 90)
			return $urandom_range(1, 3);
		else if (sel < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic req_t mk_req(input logic [2:0] op, input logic [3:0] id,
			input logic [63:0] b, input bit orm, input bit ca, input bit ct);
		req_t r;
		r.req_type     = op;
		r.flag_id      = id;
		r.bits         = b;
		r.or_mode      = orm;
		r.clear_all    = ca;
		r.clear_tested = ct;
		return r;
	endfunction

	// Bit masks shaped around the current pattern so that polls hit as well as miss.
	function automatic logic [63:0] pick_bits(input logic [3:0] id);
		logic [63:0] cur;
		logic [63:0] rnd;
		cur = tbl_valid[id] ? tbl_pattern[id] : '0;
		rnd = {$urandom, $urandom};
		case ($urandom_range(0, 8))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return cur & rnd;
			4: return cur | (64'd1 << $urandom_range(0, 63));
			5: return cur;
			6: return rnd & {$urandom, $urandom};
			default: return rnd;
		endcase
	endfunction

	function automatic req_t rand_flag_req();
		req_t r;
		int   live[$];
		int   sel;
		for (int k = 0; k < NUM_FLAGS; k++)
			if (tbl_valid[k])
				live.push_back(k);
		sel = $urandom_range(0, 99);
		if (sel < 13)
			r.req_type = REQ_CREATE;
		else if (sel < 23)
			r.req_type = REQ_DELETE;
		else if (sel < 38)
			r.req_type = REQ_SET;
		else if (sel < 50)
			r.req_type = REQ_CLEAR;
		else if (sel < 80)
			r.req_type = REQ_POLL;
		else if (sel < 95)
			r.req_type = REQ_CANCEL;
		else
			r.req_type = 3'($urandom_range(6, 7));
		if (live.size() > 0 && $urandom_range(0, 99) < 88)
			r.flag_id = 4'(live[$urandom_range(0, live.size() - 1)]);
		else
			r.flag_id = 4'($urandom_range(0, 15));
		r.bits         = pick_bits(r.flag_id);
		r.or_mode      = 1'($urandom);
		r.clear_all    = ($urandom_range(0, 3) == 0);
		r.clear_tested = 1'($urandom);
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_flag_req(input req_t r);
		int gap;
		gap = idle_en ? pick_idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(predict_flag_rsp(r));
	endtask

	task automatic wait_all_rsps();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		idle_en = 1'b0;
		// Fill every slot, then one create too many.
		send_flag_req(mk_req(REQ_CREATE, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_CREATE, 4'd1, '1, 1'b0, 1'b0, 1'b0));
		for (int i = 2; i < NUM_FLAGS; i++)
			send_flag_req(mk_req(REQ_CREATE, 4'(i), {$urandom, $urandom}, 1'b1, 1'b1, 1'b1));
		send_flag_req(mk_req(REQ_CREATE, 4'd15, '1, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_SET, 4'd0, 64'h00F0, 1'b0, 1'b0, 1'b0));
		// AND poll with only part of the tested bits present.
		send_flag_req(mk_req(REQ_POLL, 4'd0, 64'h00FF, 1'b0, 1'b1, 1'b1));
		send_flag_req(mk_req(REQ_POLL, 4'd0, 64'h000F, 1'b1, 1'b1, 1'b1));
		// Polling with an empty mask is never satisfied.
		send_flag_req(mk_req(REQ_POLL, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_POLL, 4'd0, 64'h0030, 1'b0, 1'b0, 1'b1));
		send_flag_req(mk_req(REQ_POLL, 4'd1, '1, 1'b1, 1'b1, 1'b0));
		send_flag_req(mk_req(REQ_CANCEL, 4'd1, '1, 1'b1, 1'b1, 1'b1));
		send_flag_req(mk_req(REQ_CLEAR, 4'd0, 64'h0040, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_CANCEL, 4'd0, '0, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_DELETE, 4'd0, '0, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(REQ_SET, 4'd0, '1, 1'b0, 1'b0, 1'b0));
		send_flag_req(mk_req(3'd6, 4'd15, '1, 1'b1, 1'b1, 1'b1));
		send_flag_req(mk_req(3'd7, 4'd2, '0, 1'b0, 1'b0, 1'b0));
		wait_all_rsps();
	endtask

	task automatic test_random_mix(input int n, input bit with_idle);
		idle_en = with_idle;
		for (int i = 0; i < n; i++)
			send_flag_req(rand_flag_req());
	endtask

	// The response side stops for a long stretch while requests keep coming.
	task automatic test_rsp_backpressure();
		idle_en         = 1'b0;
		rsp_hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_flag_req(rand_flag_req());
	endtask

	// Bursts separated by pauses in which every outstanding response drains.
	task automatic test_drain_pause();
		idle_en = 1'b1;
		for (int j = 0; j < 10; j++) begin
			for (int i = 0; i < 30; i++)
				send_flag_req(rand_flag_req());
			wait_all_rsps();
		end
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$error("response with no request outstanding: status %0d bits %h id %0d",
					rsp.status, rsp.result_bits, rsp.new_id);
				mismatch_count++;
			end else begin
				exp_rsp = pending_rsps.pop_front();
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.result_bits !== exp_rsp.result_bits) begin
					$error("result_bits: expected %h, got %h",
						exp_rsp.result_bits, rsp.result_bits);
					mismatch_count++;
				end
				if (rsp.new_id !== exp_rsp.new_id) begin
					$error("new_id: expected %0d, got %0d", exp_rsp.new_id, rsp.new_id);
					mismatch_count++;
				end
			end
		end
	end

	// Response side: random stalls, or a long hold-off when one is requested.
	initial begin : rsp_sink
		int n;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold_cycles > 0) begin
				n               = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				n = idle_en ? pick_idle_len() : 0;
			end
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		tbl_valid       = '0;
		mismatch_count  = 0;
		cycle_count     = 0;
		idle_en         = 1'b0;
		rsp_hold_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(500, 1'b1);
		test_random_mix(300, 1'b0);
		test_rsp_backpressure();
		test_drain_pause();
		test_random_mix(350, 1'b1);

		wait_all_rsps();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/eft_pkg.sv
hdl/eft_table.sv
hdl/event_flag_table.sv
test/event_flag_table_tb.sv
